>>> design/mime_multipart_part_locator_unit_macros.svh
// Assertion macros shared by the part locator.
// Expects clk and rst in the scope of use.
`ifndef MIME_MULTIPART_PART_LOCATOR_UNIT_MACROS_SVH
`define MIME_MULTIPART_PART_LOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define MMPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MMPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mmpl_pkg.sv
// Shared types, codes and helpers of the MIME multipart part locator.
// No dependencies.
`timescale 1ns / 1ps

package mmpl_pkg;

  localparam int MAX_BOUNDARY_BYTES_DEF = 70;
  localparam int OFFSET_BITS_DEF        = 24;
  localparam int OUT_BITS               = 24;

  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_DASH = 8'd45;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MSG  = 1'b1;

  localparam logic REG_BOUNDARY_LENGTH = 1'b0;
  localparam logic REG_PART_INDEX      = 1'b1;

  localparam logic [2:0] TRIM_CR   = 3'b001;
  localparam logic [2:0] TRIM_LF   = 3'b010;
  localparam logic [2:0] TRIM_DONE = 3'b100;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic [6:0] boundary_position;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    logic                valid;
    logic                found;
    logic [OUT_BITS-1:0] part_start;
    logic [OUT_BITS-1:0] part_length;
  } result_t;

  typedef struct packed {
    logic [2:0] flags;
    logic       inc;
  } trim_step_t;

  function automatic logic is_eol(logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  // one byte of leading trim: count bytes up to and including one EOL
  function automatic trim_step_t trim_feed(logic [2:0] flags, logic [7:0] c);
    trim_step_t r;
    logic [2:0] eol_bit;
    r.flags = flags;
    r.inc   = 1'b0;
    eol_bit = (c == CH_CR) ? TRIM_CR : TRIM_LF;
    if ((flags & TRIM_DONE) == 3'b000) begin
      if (is_eol(c)) begin
        if ((flags & eol_bit) != 3'b000) begin
          r.flags = flags | TRIM_DONE;
        end else begin
          r.flags = flags | eol_bit;
          r.inc   = 1'b1;
        end
      end else if ((flags & (TRIM_CR | TRIM_LF)) != 3'b000) begin
        r.flags = flags | TRIM_DONE;
      end else begin
        r.inc = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

>>> design/mmpl_in_if.sv
// Input channel of the part locator: valid/ready plus one byte beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface mmpl_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  logic [6:0] boundary_position;
  logic       last_byte;

  modport source (output valid, operation, data_byte, boundary_position, last_byte,
                  input ready);
  modport sink (input valid, operation, data_byte, boundary_position, last_byte,
                output ready);
endinterface

>>> design/mmpl_out_if.sv
// Result channel of the part locator: valid/ready plus found, start, length.
// Depends on nothing.
`timescale 1ns / 1ps

interface mmpl_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [23:0] part_start;
  logic [23:0] part_length;

  modport source (output valid, found, part_start, part_length, input ready);
  modport sink (input valid, found, part_start, part_length, output ready);
endinterface

>>> design/mmpl_bstore.sv
// Boundary byte store: one write port, one registered read port with a
// write-after-read bypass for the held address. Depends on nothing.
`timescale 1ns / 1ps

module mmpl_bstore #(
  parameter int MAX_BOUNDARY_BYTES = 70,
  parameter int AW = (MAX_BOUNDARY_BYTES > 1) ? $clog2(MAX_BOUNDARY_BYTES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0]    mem [MAX_BOUNDARY_BYTES];
  logic [7:0]    rd_q;
  logic [7:0]    byp_data;
  logic          byp;
  logic          byp_hit;
  logic [AW-1:0] hold_addr;

  assign byp_hit = wr_en && (rd_en ? (wr_addr == rd_addr) : (wr_addr == hold_addr));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp       <= 1'b0;
      hold_addr <= '0;
    end else if (rd_en) begin
      hold_addr <= rd_addr;
      byp       <= wr_en && (wr_addr == rd_addr);
    end else if (wr_en && (wr_addr == hold_addr)) begin
      byp <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (byp_hit) begin
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp ? byp_data : rd_q;

endmodule

>>> design/mmpl_close.sv
// Trim of a closed part: drop the leading delimiter tail and one trailing EOL.
// Depends on mmpl_pkg.
`timescale 1ns / 1ps

module mmpl_close
  import mmpl_pkg::*;
#(
  parameter int OFFSET_BITS = 24
) (
  input  logic [OFFSET_BITS-1:0] target_begin,
  input  logic [OFFSET_BITS-1:0] line_begin,
  input  logic [OFFSET_BITS-1:0] lead_count,
  input  logic [15:0]            recent_bytes,
  output logic [OFFSET_BITS-1:0] part_start,
  output logic [OFFSET_BITS-1:0] part_length
);

  logic [OFFSET_BITS-1:0] total;
  logic [OFFSET_BITS-1:0] lead;
  logic [OFFSET_BITS-1:0] rem;
  logic [OFFSET_BITS-1:0] tail;
  logic [7:0]             b1;
  logic [7:0]             b2;

  always_comb begin
    total = line_begin - target_begin;
    lead  = (lead_count > total) ? total : lead_count;
    rem   = total - lead;
    b1    = recent_bytes[7:0];
    b2    = recent_bytes[15:8];
    tail  = '0;
    if ((rem != '0) && is_eol(b1)) begin
      tail = OFFSET_BITS'(1);
      if ((rem > OFFSET_BITS'(1)) &&
          (((b2 == CH_CR) && (b1 != CH_CR)) || ((b2 == CH_LF) && (b1 != CH_LF)))) begin
        tail = OFFSET_BITS'(2);
      end
    end
    part_start  = target_begin + lead;
    part_length = rem - tail;
  end

endmodule

>>> design/mmpl_scan.sv
// Per-byte delimiter scanner: match state, part counting, trim tracking.
// Depends on mmpl_pkg, mmpl_bstore and mmpl_close.
`timescale 1ns / 1ps

module mmpl_scan
  import mmpl_pkg::*;
#(
  parameter int MAX_BOUNDARY_BYTES = MAX_BOUNDARY_BYTES_DEF,
  parameter int OFFSET_BITS        = OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  beat_t       beat,
  input  logic [6:0]  boundary_length,
  input  logic [15:0] part_index,
  output result_t     res
);

  localparam int AW = (MAX_BOUNDARY_BYTES > 1) ? $clog2(MAX_BOUNDARY_BYTES) : 1;
  localparam int MW = $clog2(MAX_BOUNDARY_BYTES + 3);
  localparam int OW = OFFSET_BITS;
  localparam logic [OW-1:0] OMAX = {OW{1'b1}};

  localparam logic [1:0] MODE_SEARCH  = 2'd0;
  localparam logic [1:0] MODE_TARGET  = 2'd1;
  localparam logic [1:0] MODE_STOPPED = 2'd2;
  localparam logic [1:0] MODE_FOUND   = 2'd3;

  localparam logic [1:0] DASH_IDLE = 2'd0;
  localparam logic [1:0] DASH_ONE  = 2'd1;
  localparam logic [1:0] DASH_TWO  = 2'd2;

  logic [MW-1:0] mp, mp_next;
  logic          als, als_next;
  logic [1:0]    mode, mode_next;
  logic [15:0]   parts, parts_next;
  logic [OW-1:0] off, off_next;
  logic [OW-1:0] tb, tb_next;
  logic [OW-1:0] ltc, ltc_next;
  logic [2:0]    ltf, ltf_next;
  logic [15:0]   recent, recent_next;
  logic [1:0]    dash, dash_next;
  logic [OW-1:0] dlb, dlb_next;

  logic [OW-1:0] ltc_fed;
  logic [2:0]    ltf_fed;
  trim_step_t    top_step;
  trim_step_t    open_step;
  logic [OW-1:0] off_inc;
  logic [MW-1:0] eff_len;
  logic [7:0]    c;
  logic          eol;
  logic          ok;
  logic          ord;
  logic          dash_before;
  logic          close_now;
  logic          bs_in_range;
  logic          ld_in_range;
  logic          wr_en;
  logic          rd_en;
  logic [7:0]    bs_data;
  logic [OW-1:0] cl_start;
  logic [OW-1:0] cl_length;

  assign c       = beat.data_byte;
  assign eol     = is_eol(c);
  assign off_inc = (off == OMAX) ? off : off + OW'(1);
  assign eff_len = ({1'b0, boundary_length} > 8'(MAX_BOUNDARY_BYTES)) ?
                   MW'(MAX_BOUNDARY_BYTES) : MW'(boundary_length);
  assign bs_in_range = MW'(mp - MW'(2)) < MW'(MAX_BOUNDARY_BYTES);
  assign ld_in_range = {2'b00, beat.boundary_position} < 9'(MAX_BOUNDARY_BYTES);

  mmpl_bstore #(
    .MAX_BOUNDARY_BYTES (MAX_BOUNDARY_BYTES)
  ) u_bstore (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (AW'(beat.boundary_position)),
    .wr_data (c),
    .rd_en   (rd_en),
    .rd_addr (AW'(mp_next - MW'(2))),
    .rd_data (bs_data)
  );

  mmpl_close #(
    .OFFSET_BITS (OW)
  ) u_close (
    .target_begin (tb),
    .line_begin   (dlb),
    .lead_count   (ltc_fed),
    .recent_bytes (recent),
    .part_start   (cl_start),
    .part_length  (cl_length)
  );

  always_comb begin
    top_step = trim_feed(ltf, c);
    ltc_fed  = ltc;
    ltf_fed  = ltf;
    if (mode == MODE_TARGET) begin
      ltf_fed = top_step.flags;
      if (top_step.inc && (ltc != OMAX)) begin
        ltc_fed = ltc + OW'(1);
      end
    end
  end

  always_comb begin
    mp_next     = mp;
    als_next    = als;
    mode_next   = mode;
    parts_next  = parts;
    off_next    = off;
    tb_next     = tb;
    ltc_next    = ltc;
    ltf_next    = ltf;
    recent_next = recent;
    dash_next   = dash;
    dlb_next    = dlb;
    ok          = 1'b0;
    ord         = 1'b0;
    dash_before = 1'b0;
    close_now   = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    open_step   = trim_feed(3'b000, c);
    res         = '0;
    if (accept) begin
      if (beat.operation == OP_LOAD) begin
        wr_en = ld_in_range;
      end else begin
        rd_en = 1'b1;
        if (off == '0) begin
          parts_next = part_index;
        end
        if ((mode == MODE_SEARCH) || (mode == MODE_TARGET)) begin
          ltc_next = ltc_fed;
          ltf_next = ltf_fed;
          if (dash == DASH_ONE) begin
            if (c == CH_DASH) begin
              dash_next   = DASH_TWO;
              als_next    = 1'b0;
              recent_next = {recent[7:0], c};
            end else begin
              ord = 1'b1;
            end
          end else if (dash == DASH_TWO) begin
            if (c == CH_DASH) begin
              dash_next = DASH_IDLE;
              mode_next = MODE_STOPPED;
            end else begin
              ord         = 1'b1;
              dash_before = 1'b1;
            end
          end else if (mp != '0) begin
            if (eol) begin
              ok = 1'b0;
            end else if (mp < MW'(2)) begin
              ok = (c == CH_DASH);
            end else begin
              ok = bs_in_range && (c == bs_data);
            end
            if (!ok) begin
              mp_next     = '0;
              als_next    = eol;
              recent_next = {CH_DASH, c};
            end else begin
              mp_next = mp + MW'(1);
              if ((mp + MW'(1)) >= (eff_len + MW'(2))) begin
                mp_next  = '0;
                als_next = 1'b0;
                if (mode == MODE_TARGET) begin
                  close_now = 1'b1;
                end else begin
                  tb_next     = off_inc;
                  dash_next   = DASH_ONE;
                  recent_next = {CH_DASH, c};
                end
              end
            end
          end else if (als && !eol) begin
            als_next = 1'b0;
            if (c == CH_DASH) begin
              dlb_next = off;
              mp_next  = MW'(1);
            end else begin
              recent_next = {recent[7:0], c};
            end
          end else begin
            als_next    = eol;
            recent_next = {recent[7:0], c};
          end

          if (ord) begin
            dash_next = DASH_IDLE;
            if (parts_next != 16'd0) begin
              parts_next = parts_next - 16'd1;
              if (parts_next == 16'd0) begin
                mode_next = MODE_TARGET;
                ltf_next  = open_step.flags;
                ltc_next  = OW'(dash_before) + OW'(open_step.inc);
              end
            end
            als_next    = eol;
            recent_next = {recent[7:0], c};
          end

          if (close_now) begin
            tb_next   = cl_start;
            dlb_next  = cl_length;
            mode_next = MODE_FOUND;
          end
        end
        off_next = off_inc;

        if (beat.last_byte) begin
          res.valid = 1'b1;
          res.found = (mode_next == MODE_FOUND);
          if (mode_next == MODE_FOUND) begin
            res.part_start  = OUT_BITS'(tb_next);
            res.part_length = OUT_BITS'(dlb_next);
          end
          mp_next     = '0;
          als_next    = 1'b1;
          mode_next   = MODE_SEARCH;
          parts_next  = 16'd0;
          off_next    = '0;
          tb_next     = '0;
          ltc_next    = '0;
          ltf_next    = 3'b000;
          recent_next = 16'd0;
          dash_next   = DASH_IDLE;
          dlb_next    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mp     <= '0;
      als    <= 1'b1;
      mode   <= MODE_SEARCH;
      parts  <= 16'd0;
      off    <= '0;
      tb     <= '0;
      ltc    <= '0;
      ltf    <= 3'b000;
      recent <= 16'd0;
      dash   <= DASH_IDLE;
      dlb    <= '0;
    end else begin
      mp     <= mp_next;
      als    <= als_next;
      mode   <= mode_next;
      parts  <= parts_next;
      off    <= off_next;
      tb     <= tb_next;
      ltc    <= ltc_next;
      ltf    <= ltf_next;
      recent <= recent_next;
      dash   <= dash_next;
      dlb    <= dlb_next;
    end
  end

endmodule

>>> design/mime_multipart_part_locator_unit.sv
// Locates one body part of a MIME multipart message. Load the boundary bytes
// (operation 0) once, set boundary_length and part_index while idle, then
// stream the message one byte per beat (operation 1), marking the final byte
// with last_byte. The block takes one beat every cycle; the result beat comes
// out in the cycle after the final byte is taken, from an output register that
// holds it while the message side keeps streaming. Per-byte cost is set by
// the single boundary-store read port: the next expected boundary byte is
// fetched at the same edge that advances the match. Input stalls only while
// a result is waiting and the result side is not ready.
// Depends on mmpl_pkg, mmpl_in_if, mmpl_out_if and mmpl_scan.
`timescale 1ns / 1ps
`include "mime_multipart_part_locator_unit_macros.svh"

module mime_multipart_part_locator_unit
  import mmpl_pkg::*;
#(
  parameter int MAX_BOUNDARY_BYTES = MAX_BOUNDARY_BYTES_DEF,
  parameter int OFFSET_BITS        = OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mmpl_in_if.sink     byte_ch,
  mmpl_out_if.source  result_ch,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [6:0]          boundary_length;
  logic [15:0]         part_index;
  logic                accept;
  beat_t               beat;
  result_t             res;
  logic                out_valid;
  logic                out_found;
  logic [OUT_BITS-1:0] out_start;
  logic [OUT_BITS-1:0] out_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      boundary_length <= 7'd1;
      part_index      <= 16'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BOUNDARY_LENGTH: boundary_length <= cfg_data[6:0];
        REG_PART_INDEX:      part_index      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign byte_ch.ready = !out_valid || result_ch.ready;
  assign accept        = byte_ch.valid && byte_ch.ready;

  assign beat.operation         = byte_ch.operation;
  assign beat.data_byte         = byte_ch.data_byte;
  assign beat.boundary_position = byte_ch.boundary_position;
  assign beat.last_byte         = byte_ch.last_byte;

  mmpl_scan #(
    .MAX_BOUNDARY_BYTES (MAX_BOUNDARY_BYTES),
    .OFFSET_BITS        (OFFSET_BITS)
  ) u_scan (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .beat            (beat),
    .boundary_length (boundary_length),
    .part_index      (part_index),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_found  <= res.found;
      out_start  <= res.part_start;
      out_length <= res.part_length;
    end
  end

  assign result_ch.valid       = out_valid;
  assign result_ch.found       = out_found;
  assign result_ch.part_start  = out_start;
  assign result_ch.part_length = out_length;

  `MMPL_ASSERT_IMP(a_stall_when_full, result_ch.valid && !result_ch.ready, !byte_ch.ready, "input taken while result blocked")
  `MMPL_ASSERT_IMP(a_result_cause, $rose(result_ch.valid), $past(accept && (byte_ch.operation == OP_MSG) && byte_ch.last_byte), "result without final byte")
  `MMPL_ASSERT_IMP(a_zero_not_found, result_ch.valid && !result_ch.found, (result_ch.part_start == '0) && (result_ch.part_length == '0), "nonzero fields when not found")
  `MMPL_ASSERT_NEXT(a_load_no_result, accept && (byte_ch.operation == OP_LOAD) && !result_ch.valid, !result_ch.valid, "boundary load produced a result")

endmodule
